[rtl/core/assert_macros.svh]
// Assertion macros used by the top RTL file of the sorted priority queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tksq_pkg.sv]
// Types and codes shared by the two-key sorted priority queue modules
package tksq_pkg;

  // Command codes of an input beat
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } cmd_op_t;

  // Status codes of a result beat
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry; priority and treatment together form the sort key
  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  treat;
    logic [15:0] tag;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

[rtl/core/tksq_ctrl.sv]
// Controller of the sorted priority queue: input capture, execute step, result beat
module tksq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tksq_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence one beat: capture, then execute once the result register is free
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/tksq_datapath.sv]
// Datapath of the sorted priority queue: row of sorted entry cells and result register
module tksq_datapath #(
  parameter int DEPTH = 16,
  parameter int OCC_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tksq_pkg::dp_cmd_t cmd,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_priority_req,
  input  logic [7:0]        in_treatment,
  input  logic [15:0]       in_patient_tag,
  output logic              out_head_valid,
  output logic [7:0]        out_head_priority,
  output logic [7:0]        out_head_treatment,
  output logic [15:0]       out_head_tag,
  output logic [4:0]        out_entry_count,
  output logic [1:0]        out_status,
  output logic [OCC_W-1:0]  occupancy
);

  tksq_pkg::cmd_op_t       op_r;
  tksq_pkg::entry_t        new_r;
  tksq_pkg::entry_t        cells_r   [DEPTH];
  tksq_pkg::entry_t        cells_nxt [DEPTH];
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [DEPTH-1:0]        keep;
  logic                    full, empty;
  tksq_pkg::status_t       status_nxt;
  logic [OCC_W+4:0]        cnt_wide;
  tksq_pkg::entry_t        head_nxt;

  // Mark live cells whose key does not exceed the new key; a prefix, as the row is sorted
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      keep[k] = (OCC_W'(k) < occ_r) &&
                ({cells_r[k].prio, cells_r[k].treat} <= {new_r.prio, new_r.treat});
    end
  end

  assign full  = (occ_r == OCC_W'(DEPTH));
  assign empty = (occ_r == '0);

  // Work out the next row contents, occupancy and status
  always_comb begin
    cells_nxt  = cells_r;
    occ_nxt    = occ_r;
    status_nxt = tksq_pkg::ST_OK;
    case (op_r)
      tksq_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = tksq_pkg::ST_FULL;
        end else begin
          occ_nxt = occ_r + 1'b1;
          if (!keep[0]) begin
            cells_nxt[0] = new_r;
          end
          for (int k = 1; k < DEPTH; k++) begin
            if (!keep[k]) begin
              cells_nxt[k] = keep[k-1] ? new_r : cells_r[k-1];
            end
          end
        end
      end
      tksq_pkg::OP_DEQUEUE: begin
        if (empty) begin
          status_nxt = tksq_pkg::ST_EMPTY;
        end else begin
          occ_nxt = occ_r - 1'b1;
          for (int k = 0; k < DEPTH - 1; k++) begin
            cells_nxt[k] = cells_r[k+1];
          end
        end
      end
      tksq_pkg::OP_CLEAR: begin
        occ_nxt = '0;
      end
      tksq_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign head_nxt = cells_nxt[0];
  assign cnt_wide = {5'd0, occ_nxt};

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= tksq_pkg::cmd_op_t'(in_command);
      new_r.prio  <= in_priority_req;
      new_r.treat <= in_treatment;
      new_r.tag   <= in_patient_tag;
    end
  end

  // Advance the entry row; entries need no reset
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      cells_r <= cells_nxt;
    end
  end

  // Hold occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.execute) begin
      occ_r <= occ_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_head_valid     <= (occ_nxt != '0);
      out_head_priority  <= (occ_nxt != '0) ? head_nxt.prio  : 8'd0;
      out_head_treatment <= (occ_nxt != '0) ? head_nxt.treat : 8'd0;
      out_head_tag       <= (occ_nxt != '0) ? head_nxt.tag   : 16'd0;
      out_entry_count    <= cnt_wide[4:0];
      out_status         <= status_nxt;
    end
  end

  assign occupancy = occ_r;

endmodule

[rtl/core/two_key_sorted_priority_queue.sv]
// A result beat is offered once its captured input beat has passed the execute step,
// which waits while an earlier result is held by a stalled output. Each command is a
// capture, then one execute step (every entry cell compares and shifts in parallel),
// before the next input beat is taken, which may be while a result waits on a stalled output.
// Reset (synchronous, active low) empties the queue and clears the handshake;
// entry cells are not reset.
`include "assert_macros.svh"

module two_key_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_priority_req,
  input  logic [7:0]  in_treatment,
  input  logic [15:0] in_patient_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_head_valid,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_head_treatment,
  output logic [15:0] out_head_tag,
  output logic [4:0]  out_entry_count,
  output logic [1:0]  out_status
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  tksq_pkg::dp_cmd_t cmd;
  logic [OCC_W-1:0]  occupancy;
  logic              in_accept;
  logic              out_empty;
  logic              head_zero;

  tksq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tksq_datapath #(
    .DEPTH (DEPTH),
    .OCC_W (OCC_W)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_command         (in_command),
    .in_priority_req    (in_priority_req),
    .in_treatment       (in_treatment),
    .in_patient_tag     (in_patient_tag),
    .out_head_valid     (out_head_valid),
    .out_head_priority  (out_head_priority),
    .out_head_treatment (out_head_treatment),
    .out_head_tag       (out_head_tag),
    .out_entry_count    (out_entry_count),
    .out_status         (out_status),
    .occupancy          (occupancy)
  );

  // Terms watched by the checks below
  assign in_accept = in_valid && !in_stall;
  assign out_empty = out_valid && !out_head_valid;
  assign head_zero = (out_head_priority == 8'd0) && (out_head_treatment == 8'd0) &&
                     (out_head_tag == 16'd0);

  // Occupancy never passes the queue depth
  `ASSERT_IMPLY(a_occ_bound, clk, rst_n, 1'b1, occupancy <= OCC_W'(DEPTH), "occupancy above depth")

  // An accepted beat is executed before another is taken
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall, "beat taken while busy")

  // An empty queue reports a zero head
  `ASSERT_IMPLY(a_empty_head_zero, clk, rst_n, out_empty, head_zero, "nonzero head on empty queue")

endmodule

[tb/queue_head_monitor.sv]
// Queue head monitor: predicts every result beat of the sorted priority queue and compares it
module queue_head_monitor #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_priority_req,
  input  logic [7:0]  in_treatment,
  input  logic [15:0] in_patient_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_head_valid,
  input  logic [7:0]  out_head_priority,
  input  logic [7:0]  out_head_treatment,
  input  logic [15:0] out_head_tag,
  input  logic [4:0]  out_entry_count,
  input  logic [1:0]  out_status,
  output int unsigned fail_count,
  output int unsigned owed
);

  // What one result beat should carry
  typedef struct packed {
    logic                present;
    logic [7:0]          prio;
    logic [7:0]          treat;
    logic [15:0]         tag;
    logic [4:0]          count;
    tksq_pkg::status_t   status;
  } head_report_t;

  tksq_pkg::entry_t held [DEPTH];
  int               occupancy;
  head_report_t     reports_due [$];
  int unsigned      beat_no;

  initial begin
    fail_count = 0;
    owed       = 0;
    occupancy  = 0;
    beat_no    = 0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    $display("%0t head_mon: result beat %0d: %s", $time, beat_no, what);
    fail_count++;
  endtask

  // Apply one command to the shadow queue and return the head report it causes
  function automatic head_report_t apply_command(input tksq_pkg::cmd_op_t cmd,
                                                 input tksq_pkg::entry_t item);
    head_report_t rep;
    int           pos;
    int           k;
    rep.status = tksq_pkg::ST_OK;
    case (cmd)
      tksq_pkg::OP_INSERT: begin
        if (occupancy >= DEPTH) begin
          rep.status = tksq_pkg::ST_FULL;
        end else begin
          // place after every entry whose key is not greater, so ties stay in arrival order
          pos = 0;
          while (pos < occupancy &&
                 {held[pos].prio, held[pos].treat} <= {item.prio, item.treat})
            pos++;
          for (k = occupancy; k > pos; k--)
            held[k] = held[k-1];
          held[pos] = item;
          occupancy++;
        end
      end
      tksq_pkg::OP_DEQUEUE: begin
        if (occupancy == 0) begin
          rep.status = tksq_pkg::ST_EMPTY;
        end else begin
          for (k = 1; k < occupancy; k++)
            held[k-1] = held[k];
          occupancy--;
        end
      end
      tksq_pkg::OP_CLEAR: begin
        occupancy = 0;
      end
      default: ;
    endcase
    if (occupancy > 0) begin
      rep.present = 1'b1;
      rep.prio    = held[0].prio;
      rep.treat   = held[0].treat;
      rep.tag     = held[0].tag;
    end else begin
      rep.present = 1'b0;
      rep.prio    = '0;
      rep.treat   = '0;
      rep.tag     = '0;
    end
    rep.count = occupancy[4:0];
    return rep;
  endfunction

  // Check the result beat first, then predict from the input beat
  always @(posedge clk) begin : watch
    head_report_t     want;
    tksq_pkg::entry_t item;
    if (!rst_n) begin
      occupancy = 0;
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, count %0d status %0d",
                                    out_entry_count, out_status));
        end else begin
          want = reports_due.pop_front();
          if (out_head_valid !== want.present)
            report_mismatch($sformatf("head_valid %0b, want %0b", out_head_valid, want.present));
          if (out_head_priority !== want.prio)
            report_mismatch($sformatf("head_priority %0d, want %0d",
                                      out_head_priority, want.prio));
          if (out_head_treatment !== want.treat)
            report_mismatch($sformatf("head_treatment %0d, want %0d",
                                      out_head_treatment, want.treat));
          if (out_head_tag !== want.tag)
            report_mismatch($sformatf("head_tag %h, want %h", out_head_tag, want.tag));
          if (out_entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count, want.count));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        end
        beat_no++;
      end
      if (in_valid && !in_stall) begin
        item.prio  = in_priority_req;
        item.treat = in_treatment;
        item.tag   = in_patient_tag;
        reports_due.push_back(apply_command(tksq_pkg::cmd_op_t'(in_command), item));
      end
    end
    owed <= reports_due.size();
  end

endmodule

[tb/tb.sv]
// Top of the sorted priority queue testbench: clock, reset, stimulus, back-pressure and verdict
module tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASES     = 19;
  localparam int PHASE_LEN  = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = tksq_pkg::OP_NOP;
  logic [7:0]  in_priority_req = '0;
  logic [7:0]  in_treatment = '0;
  logic [15:0] in_patient_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_head_valid;
  logic [7:0]  out_head_priority;
  logic [7:0]  out_head_treatment;
  logic [15:0] out_head_tag;
  logic [4:0]  out_entry_count;
  logic [1:0]  out_status;

  int unsigned fail_count;
  int unsigned owed;
  int          idle_cycles = 0;
  bit          sender_calm = 1'b0;

  always #10 clk = ~clk;

  two_key_sorted_priority_queue #(.DEPTH(16)) dut (.*);

  queue_head_monitor #(.DEPTH(16)) head_mon (.*);

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one input beat after a random gap and hold it until taken
  task automatic send_beat(input tksq_pkg::cmd_op_t cmd, input logic [7:0] prio,
                           input logic [7:0] treat, input logic [15:0] tag);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_priority_req <= prio;
    in_treatment    <= treat;
    in_patient_tag  <= tag;
    do @(posedge clk); while (in_stall);
  endtask

  // Drive the output stall to one value over a span set by n, adding the span to cycles
  task automatic hold_stall(input logic value, input int n, inout int cycles);
    repeat (n) begin
      @(negedge clk);
      out_stall <= value;
      cycles++;
    end
  endtask

  // Reset, then the directed beats, then random phases
  initial begin : stimulus
    int                phase;
    int                n;
    int                r;
    int                insert_pct;
    bit                narrow;
    tksq_pkg::cmd_op_t cmd;
    logic [7:0]        prio;
    logic [7:0]        treat;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // empty queue corner cases
    send_beat(tksq_pkg::OP_NOP,     8'd0,   8'd0,   16'h0000);
    send_beat(tksq_pkg::OP_DEQUEUE, 8'd0,   8'd0,   16'h0000);
    send_beat(tksq_pkg::OP_CLEAR,   8'hff,  8'hff,  16'hffff);
    // key extremes and ties on both keys
    send_beat(tksq_pkg::OP_INSERT,  8'hff,  8'hff,  16'hffff);
    send_beat(tksq_pkg::OP_INSERT,  8'h00,  8'h00,  16'h0000);
    send_beat(tksq_pkg::OP_INSERT,  8'h00,  8'h00,  16'h0001);
    send_beat(tksq_pkg::OP_INSERT,  8'h00,  8'h00,  16'h0002);
    send_beat(tksq_pkg::OP_INSERT,  8'h00,  8'hff,  16'h1234);
    send_beat(tksq_pkg::OP_INSERT,  8'hff,  8'h00,  16'haaaa);
    send_beat(tksq_pkg::OP_INSERT,  8'h80,  8'h80,  16'h5555);
    send_beat(tksq_pkg::OP_NOP,     8'h12,  8'h34,  16'h5678);
    send_beat(tksq_pkg::OP_DEQUEUE, 8'h00,  8'h00,  16'h0000);
    send_beat(tksq_pkg::OP_DEQUEUE, 8'h00,  8'h00,  16'h0000);
    send_beat(tksq_pkg::OP_DEQUEUE, 8'h00,  8'h00,  16'h0000);
    send_beat(tksq_pkg::OP_CLEAR,   8'h00,  8'h00,  16'h0000);
    send_beat(tksq_pkg::OP_DEQUEUE, 8'h00,  8'h00,  16'h0000);
    // secondary key breaks a primary tie, primary key wins over secondary
    send_beat(tksq_pkg::OP_INSERT,  8'd7,   8'd7,   16'h0001);
    send_beat(tksq_pkg::OP_INSERT,  8'd7,   8'd7,   16'h0002);
    send_beat(tksq_pkg::OP_INSERT,  8'd7,   8'd6,   16'h0003);
    send_beat(tksq_pkg::OP_INSERT,  8'd6,   8'd7,   16'h0004);
    repeat (4) send_beat(tksq_pkg::OP_DEQUEUE, 8'h00, 8'h00, 16'h0000);

    // cycle through filling, draining and balanced phases
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 3)
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 49;
      endcase
      narrow      = 1'($urandom_range(0, 1));
      sender_calm = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct)
          cmd = tksq_pkg::OP_INSERT;
        else if (r < 97)
          cmd = tksq_pkg::OP_DEQUEUE;
        else if (r == 97)
          cmd = tksq_pkg::OP_CLEAR;
        else
          cmd = tksq_pkg::OP_NOP;
        // narrow keys give many equal keys, to exercise arrival order on ties
        if (narrow) begin
          prio  = 8'($urandom_range(0, 3));
          treat = 8'($urandom_range(0, 3));
        end else begin
          prio  = 8'($urandom);
          treat = 8'($urandom);
        end
        send_beat(cmd, prio, treat, 16'($urandom));
      end
    end
    sender_calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // Random back-pressure on the result side, with calm stretches and one long hold-off
  initial begin : receiver
    int  cycles;
    bit  hold_done;
    cycles    = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && cycles >= HOLD_START) begin
        // stall the result side while the sender keeps offering, so a beat waits behind the held result
        hold_stall(1'b1, HOLD_LEN, cycles);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 10) begin
        hold_stall(1'b0, $urandom_range(40, 80), cycles);
      end else begin
        hold_stall(1'b0, $urandom_range(1, 5), cycles);
        hold_stall(1'b1, pick_gap(), cycles);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tksq_pkg.sv
rtl/core/tksq_ctrl.sv
rtl/core/tksq_datapath.sv
rtl/core/two_key_sorted_priority_queue.sv
tb/queue_head_monitor.sv
tb/tb.sv
